/* rtl/ddo_pkg.sv */
// Package with the shared types, constants and angle table of the odometry block.
`default_nettype none
package ddo_pkg;

    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int STEP_W           = 5;
    localparam int DIV_DIGITS       = 18;
    localparam int IN_W             = 112;
    localparam int OUT_W            = 112;

    localparam logic [1:0] MODE_ENC     = 2'd0;
    localparam logic [1:0] MODE_LOAD_XY = 2'd1;
    localparam logic [1:0] MODE_LOAD_HD = 2'd2;
    localparam logic [1:0] MODE_HOLD    = 2'd3;

    localparam logic [1:0] REG_DIST  = 2'd0;
    localparam logic [1:0] REG_TURN  = 2'd1;
    localparam logic [1:0] REG_RATE  = 2'd2;

    localparam logic [33:0] CORDIC_X0 = 34'sd652032874;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_R, ST_MUL_A, ST_MUL_V, ST_PREP,
        ST_LOOP, ST_MUL_X, ST_MUL_Y, ST_FIN
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_CAPTURE, OP_MUL_R, OP_MUL_A, OP_MUL_V,
        OP_PREP, OP_STEP, OP_MUL_X, OP_MUL_Y, OP_FIN
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [STEP_W-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic in_is_enc;
    } status_t;

    function automatic logic [31:0] atan_entry(input logic [STEP_W-1:0] i);
        logic [31:0] v;
        begin
            unique case (i)
                5'd0:    v = 32'h20000000;
                5'd1:    v = 32'h12E4051E;
                5'd2:    v = 32'h09FB385B;
                5'd3:    v = 32'h051111D4;
                5'd4:    v = 32'h028B0D43;
                5'd5:    v = 32'h0145D7E1;
                5'd6:    v = 32'h00A2F61E;
                5'd7:    v = 32'h00517C55;
                5'd8:    v = 32'h0028BE53;
                5'd9:    v = 32'h00145F2F;
                5'd10:   v = 32'h000A2F98;
                5'd11:   v = 32'h000517CC;
                5'd12:   v = 32'h00028BE6;
                5'd13:   v = 32'h000145F3;
                5'd14:   v = 32'h0000A2F9;
                5'd15:   v = 32'h0000517D;
                5'd16:   v = 32'h000028BE;
                5'd17:   v = 32'h0000145F;
                5'd18:   v = 32'h00000A30;
                5'd19:   v = 32'h00000518;
                5'd20:   v = 32'h0000028C;
                5'd21:   v = 32'h00000146;
                5'd22:   v = 32'h000000A3;
                5'd23:   v = 32'h00000051;
                default: v = 32'h00000000;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/ddo_datapath.sv */
// Datapath of the odometry block: registers, shared multiplier, CORDIC and divider.
`default_nettype none
module ddo_datapath #(
    parameter int ANGLE_BITS   = ddo_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire ddo_pkg::cmd_t             cmd,
    output ddo_pkg::status_t               status,
    input  wire logic [1:0]                s_tuser,
    input  wire logic [ddo_pkg::IN_W-1:0]  s_tdata,
    output logic [ddo_pkg::OUT_W-1:0]      m_tdata,
    input  wire logic                      cfg_we,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [31:0]               cfg_data
);

    localparam logic [31:0] ANGLE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    logic [23:0]        dpt_reg;
    logic [31:0]        tpt_reg;
    logic [15:0]        rate_reg;
    logic [1:0]         mode_reg;
    logic signed [16:0] sum_reg, diff_reg;
    logic [31:0]        ldx_reg, ldy_reg;
    logic [15:0]        ldh_reg;
    logic signed [67:0] prod_reg;
    logic signed [31:0] r8_reg;
    logic signed [48:0] alpha_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic               neg_reg;
    logic [35:0]        div_reg;
    logic [2:0]         rem_reg;
    logic [31:0]        x_reg, y_reg, spd_reg;
    logic [15:0]        hd_reg;
    logic [ddo_pkg::OUT_W-1:0] out_reg;

    logic signed [34:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [67:0] mul_p;
    logic [31:0]        mag;
    logic signed [34:0] cos_v, sin_v;
    logic signed [67:0] rnd_sum;
    logic [31:0]        delta;
    logic [67:0]        cur_sum;
    logic [31:0]        cur;
    logic [35:0]        num;
    logic [31:0]        mid, ang;
    logic [48:0]        hd_sum;
    logic [4:0]         dv_t;
    logic [1:0]         dv_q;
    logic signed [33:0] sh_x, sh_y, atan_v;
    logic [31:0]        x_next, y_next, spd_next;
    logic [15:0]        hd_next;

    assign status.in_is_enc = (s_tuser == ddo_pkg::MODE_ENC);
    assign m_tdata = out_reg;

    always_comb
    begin
        mag    = r8_reg[31] ? 32'(-r8_reg) : 32'(r8_reg);
        cos_v  = neg_reg ? -35'(cx_reg) : 35'(cx_reg);
        sin_v  = neg_reg ? -35'(cy_reg) : 35'(cy_reg);
        mul_a  = '0;
        mul_b  = '0;
        unique case (cmd.op)
            ddo_pkg::OP_MUL_R:
            begin
                mul_a = 35'(sum_reg);
                mul_b = $signed({9'd0, dpt_reg});
            end
            ddo_pkg::OP_MUL_A:
            begin
                mul_a = 35'(diff_reg);
                mul_b = $signed({1'b0, tpt_reg});
            end
            ddo_pkg::OP_MUL_V:
            begin
                mul_a = $signed({3'd0, mag});
                mul_b = $signed({17'd0, rate_reg});
            end
            ddo_pkg::OP_MUL_X:
            begin
                mul_a = cos_v;
                mul_b = 33'(r8_reg);
            end
            ddo_pkg::OP_MUL_Y:
            begin
                mul_a = sin_v;
                mul_b = 33'(r8_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p   = 68'(mul_a) * 68'(mul_b);
        rnd_sum = prod_reg + (68'sd1 <<< 37);
        delta   = 32'(rnd_sum >>> 38);
        cur_sum = 68'(prod_reg) + 68'd128;
        cur     = (cur_sum[67:40] != '0) ? 32'hFFFF_FFFF : cur_sum[39:8];
        num     = {2'b00, spd_reg, 2'b00} + {4'd0, cur} + 36'd2;
        mid     = {hd_reg, 16'd0} + alpha_reg[32:1];
        ang     = mid & ANGLE_MASK;
        hd_sum  = 49'(alpha_reg) + 49'h8000;
        dv_t    = {rem_reg, div_reg[35:34]};
        if (dv_t >= 5'd15)
            dv_q = 2'd3;
        else if (dv_t >= 5'd10)
            dv_q = 2'd2;
        else if (dv_t >= 5'd5)
            dv_q = 2'd1;
        else
            dv_q = 2'd0;
        sh_x   = cx_reg >>> cmd.step;
        sh_y   = cy_reg >>> cmd.step;
        atan_v = $signed({2'b00, ddo_pkg::atan_entry(cmd.step)});
        x_next   = x_reg;
        y_next   = y_reg;
        hd_next  = hd_reg;
        spd_next = spd_reg;
        if (cmd.op == ddo_pkg::OP_FIN)
        begin
            unique case (mode_reg)
                ddo_pkg::MODE_ENC:
                begin
                    y_next   = y_reg + delta;
                    hd_next  = hd_reg + hd_sum[31:16];
                    spd_next = div_reg[31:0];
                end
                ddo_pkg::MODE_LOAD_XY:
                begin
                    x_next = ldx_reg;
                    y_next = ldy_reg;
                end
                ddo_pkg::MODE_LOAD_HD: hd_next = ldh_reg;
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dpt_reg  <= 24'd65536;
            tpt_reg  <= 32'd65536;
            rate_reg <= 16'd100;
            x_reg    <= '0;
            y_reg    <= '0;
            hd_reg   <= '0;
            spd_reg  <= '0;
            out_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ddo_pkg::REG_DIST: dpt_reg  <= cfg_data[23:0];
                    ddo_pkg::REG_TURN: tpt_reg  <= cfg_data;
                    ddo_pkg::REG_RATE: rate_reg <= cfg_data[15:0];
                    default:           ;
                endcase
            end
            if (cmd.op == ddo_pkg::OP_MUL_Y)
                x_reg <= x_reg + delta;
            if (cmd.op == ddo_pkg::OP_FIN)
            begin
                x_reg   <= x_next;
                y_reg   <= y_next;
                hd_reg  <= hd_next;
                spd_reg <= spd_next;
                out_reg <= {spd_next, hd_next, y_next, x_next};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op inside {ddo_pkg::OP_MUL_R, ddo_pkg::OP_MUL_A, ddo_pkg::OP_MUL_V,
                           ddo_pkg::OP_MUL_X, ddo_pkg::OP_MUL_Y})
            prod_reg <= mul_p;
        unique case (cmd.op)
            ddo_pkg::OP_CAPTURE:
            begin
                mode_reg <= s_tuser;
                sum_reg  <= 17'(signed'(s_tdata[15:0])) + 17'(signed'(s_tdata[31:16]));
                diff_reg <= 17'(signed'(s_tdata[15:0])) - 17'(signed'(s_tdata[31:16]));
                ldx_reg  <= s_tdata[63:32];
                ldy_reg  <= s_tdata[95:64];
                ldh_reg  <= s_tdata[111:96];
            end
            ddo_pkg::OP_MUL_A: r8_reg <= prod_reg[40:9];
            ddo_pkg::OP_MUL_V: alpha_reg <= prod_reg[48:0];
            ddo_pkg::OP_PREP:
            begin
                neg_reg <= (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
                cz_reg  <= 34'(signed'({ang[31] ^ (ang[31] ^ ang[30]), ang[30:0]}));
                cx_reg  <= ddo_pkg::CORDIC_X0;
                cy_reg  <= '0;
                div_reg <= num;
                rem_reg <= '0;
            end
            ddo_pkg::OP_STEP:
            begin
                if (cmd.step < ddo_pkg::STEP_W'(CORDIC_STEPS))
                begin
                    if (!cz_reg[33])
                    begin
                        cx_reg <= cx_reg - sh_y;
                        cy_reg <= cy_reg + sh_x;
                        cz_reg <= cz_reg - atan_v;
                    end
                    else
                    begin
                        cx_reg <= cx_reg + sh_y;
                        cy_reg <= cy_reg - sh_x;
                        cz_reg <= cz_reg + atan_v;
                    end
                end
                if (cmd.step < 5'(ddo_pkg::DIV_DIGITS))
                begin
                    rem_reg <= 3'(dv_t - 5'(dv_q) * 5'd5);
                    div_reg <= {div_reg[33:0], dv_q};
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/ddo_ctrl.sv */
// Controller state machine of the odometry block: sequences the datapath and owns the handshakes.
`default_nettype none
module ddo_ctrl #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ddo_pkg::status_t status,
    output ddo_pkg::cmd_t         cmd,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  wire logic             m_tready
);

    localparam int LOOP_N = (CORDIC_STEPS > ddo_pkg::DIV_DIGITS) ?
                            CORDIC_STEPS : ddo_pkg::DIV_DIGITS;

    ddo_pkg::state_t             state_reg, state_next;
    logic [ddo_pkg::STEP_W-1:0]  cnt_reg, cnt_next;
    logic                        valid_reg, valid_next;
    logic                        out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ddo_pkg::ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        out_free   = !valid_reg || m_tready;
        valid_next = valid_reg && !m_tready;
        s_tready   = 1'b0;
        cmd.op     = ddo_pkg::OP_NONE;
        cmd.step   = cnt_reg;
        unique case (state_reg)
            ddo_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op     = ddo_pkg::OP_CAPTURE;
                    state_next = status.in_is_enc ? ddo_pkg::ST_MUL_R : ddo_pkg::ST_FIN;
                end
            end
            ddo_pkg::ST_MUL_R:
            begin
                cmd.op     = ddo_pkg::OP_MUL_R;
                state_next = ddo_pkg::ST_MUL_A;
            end
            ddo_pkg::ST_MUL_A:
            begin
                cmd.op     = ddo_pkg::OP_MUL_A;
                state_next = ddo_pkg::ST_MUL_V;
            end
            ddo_pkg::ST_MUL_V:
            begin
                cmd.op     = ddo_pkg::OP_MUL_V;
                state_next = ddo_pkg::ST_PREP;
            end
            ddo_pkg::ST_PREP:
            begin
                cmd.op     = ddo_pkg::OP_PREP;
                cnt_next   = '0;
                state_next = ddo_pkg::ST_LOOP;
            end
            ddo_pkg::ST_LOOP:
            begin
                cmd.op   = ddo_pkg::OP_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ddo_pkg::STEP_W'(LOOP_N - 1))
                    state_next = ddo_pkg::ST_MUL_X;
            end
            ddo_pkg::ST_MUL_X:
            begin
                cmd.op     = ddo_pkg::OP_MUL_X;
                state_next = ddo_pkg::ST_MUL_Y;
            end
            ddo_pkg::ST_MUL_Y:
            begin
                cmd.op     = ddo_pkg::OP_MUL_Y;
                state_next = ddo_pkg::ST_FIN;
            end
            ddo_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.op     = ddo_pkg::OP_FIN;
                    valid_next = 1'b1;
                    state_next = ddo_pkg::ST_IDLE;
                end
            end
            default: state_next = ddo_pkg::ST_IDLE;
        endcase
        m_tvalid = valid_reg;
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg != ddo_pkg::ST_IDLE)
        else $error("accepted word did not start processing");

    a_fin_waits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ddo_pkg::ST_FIN && valid_reg && !m_tready |=> state_reg == ddo_pkg::ST_FIN)
        else $error("result overwritten while the previous word was held");

    a_loop_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ddo_pkg::ST_LOOP |-> cnt_reg < ddo_pkg::STEP_W'(LOOP_N))
        else $error("iteration count out of range");

endmodule
`default_nettype wire

/* rtl/differential_drive_odometry.sv */
// Top level of the two-wheel dead-reckoning pose tracker.
// The slave stream takes one word per update: tuser carries the mode (0 encoder
// update, 1 load position, 2 load heading, 3 no change) and tdata the counts and
// load values. The master stream returns one word per accepted word with the
// position, heading and filtered speed after that update.
// The user writes the configuration registers (distance per tick, turn per tick,
// refresh rate) through cfg_we, cfg_index and cfg_data only while the block is
// idle; the block itself does not enforce this. An encoder update raises m_tvalid
// after three passes through the shared multiplier, a preparation step, the
// iterations in which the CORDIC and the radix-4 divide by five run side by side,
// two more multiplier passes and a write-back into the output register. A load
// or no-change word goes from acceptance straight to the write-back.
// The input is free again in the cycle after the write-back, so a new word is
// taken only once the previous one is written back. A new word is accepted
// while a finished result still waits in the output register.
// Reset clears the pose and speed and restores the register defaults.
// If the receiver stalls, the next result waits in its final cycle until the
// output register is taken.
`default_nettype none
module differential_drive_odometry #(
    parameter int ANGLE_BITS   = ddo_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // left_count, right_count, load_x, load_y, load_heading
    input  wire logic [ddo_pkg::IN_W-1:0]  s_tdata,
    // mode
    input  wire logic [1:0]                s_tuser,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // pos_x, pos_y, heading, speed
    output logic [ddo_pkg::OUT_W-1:0]      m_tdata,
    input  wire logic                      cfg_we,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [31:0]               cfg_data
);

    ddo_pkg::cmd_t    cmd;
    ddo_pkg::status_t status;

    ddo_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .status   (status),
        .cmd      (cmd),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    ddo_datapath #(
        .ANGLE_BITS(ANGLE_BITS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
`default_nettype wire

/* verif/odometry_checker.sv */
// Checker that predicts the pose and speed results of the odometry block and compares them.
`default_nettype none
module odometry_checker (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_tvalid,
    input  wire logic                     s_tready,
    input  wire logic [ddo_pkg::IN_W-1:0] s_tdata,
    input  wire logic [1:0]               s_tuser,
    input  wire logic                     m_tvalid,
    input  wire logic                     m_tready,
    input  wire logic [ddo_pkg::OUT_W-1:0] m_tdata,
    input  wire logic                     cfg_we,
    input  wire logic [1:0]               cfg_index,
    input  wire logic [31:0]              cfg_data,
    output int                            fail_count,
    output int                            pending,
    output int                            results_seen
);

    logic [23:0] dist_per_tick;
    logic [31:0] turn_per_tick;
    logic [15:0] rate_hz;
    logic [31:0] pose_x;
    logic [31:0] pose_y;
    logic [15:0] pose_heading;
    logic [31:0] speed_filt;
    logic [ddo_pkg::OUT_W-1:0] pose_queue[$];

    function automatic longint floor_shift(input longint v, input int s);
        return v >>> s;
    endfunction

    task automatic rotate_unit(input logic [31:0] ang, output longint c, output longint s);
        longint cx;
        longint cy;
        longint z;
        longint t;
        logic flip;
        flip = 1'b0;
        cx = 652032874;
        cy = 0;
        if (ang[31:30] == 2'd1 || ang[31:30] == 2'd2)
        begin
            ang = ang + 32'h80000000;
            flip = 1'b1;
        end
        z = longint'($signed(ang));
        for (int i = 0; i < ddo_pkg::CORDIC_STEPS_DEF; i++)
        begin
            if (z >= 0)
            begin
                t = cx - floor_shift(cy, i);
                cy = cy + floor_shift(cx, i);
                z = z - longint'(ddo_pkg::atan_entry(i[4:0]));
            end
            else
            begin
                t = cx + floor_shift(cy, i);
                cy = cy - floor_shift(cx, i);
                z = z + longint'(ddo_pkg::atan_entry(i[4:0]));
            end
            cx = t;
        end
        c = flip ? -cx : cx;
        s = flip ? -cy : cy;
    endtask

    task automatic advance_pose(input logic [1:0] mode, input logic [ddo_pkg::IN_W-1:0] d);
        longint lc;
        longint rc;
        longint travel;
        longint turn;
        logic [31:0] mid;
        logic [31:0] phase;
        longint c;
        longint s;
        longint dx;
        longint dy;
        longint mag;
        longint cur;
        lc = longint'($signed(d[15:0]));
        rc = longint'($signed(d[31:16]));
        if (mode == ddo_pkg::MODE_ENC)
        begin
            travel = floor_shift((lc + rc) * longint'(dist_per_tick), 9);
            turn = (lc - rc) * longint'(turn_per_tick);
            mid = {pose_heading, 16'h0} + 32'(turn >>> 1);
            phase = (mid >> (32 - ddo_pkg::ANGLE_BITS_DEF)) << (32 - ddo_pkg::ANGLE_BITS_DEF);
            rotate_unit(phase, c, s);
            dx = floor_shift(travel * c + (64'sd1 <<< 37), 38);
            dy = floor_shift(travel * s + (64'sd1 <<< 37), 38);
            pose_x = pose_x + 32'(dx);
            pose_y = pose_y + 32'(dy);
            pose_heading = pose_heading + 16'((turn + 32768) >>> 16);
            mag = travel < 0 ? -travel : travel;
            cur = (mag * longint'(rate_hz) + 128) >>> 8;
            if (cur > 64'hFFFFFFFF)
                cur = 64'hFFFFFFFF;
            speed_filt = 32'((4 * longint'(speed_filt) + cur + 2) / 5);
        end
        else if (mode == ddo_pkg::MODE_LOAD_XY)
        begin
            pose_x = d[63:32];
            pose_y = d[95:64];
        end
        else if (mode == ddo_pkg::MODE_LOAD_HD)
        begin
            pose_heading = d[111:96];
        end
        pose_queue.push_back({speed_filt, pose_heading, pose_y, pose_x});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [ddo_pkg::OUT_W-1:0] want;
        if (!rst_n)
        begin
            dist_per_tick <= 24'd65536;
            turn_per_tick <= 32'd65536;
            rate_hz <= 16'd100;
            pose_x = '0;
            pose_y = '0;
            pose_heading = '0;
            speed_filt = '0;
            pose_queue.delete();
            fail_count <= 0;
            pending <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ddo_pkg::REG_DIST: dist_per_tick <= cfg_data[23:0];
                    ddo_pkg::REG_TURN: turn_per_tick <= cfg_data;
                    ddo_pkg::REG_RATE: rate_hz <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                advance_pose(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                if (pose_queue.size() == 0)
                begin
                    $error("result with no expectation waiting: %h", m_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = pose_queue.pop_front();
                    if (m_tdata[31:0] !== want[31:0])
                        $error("pos_x expected %0d actual %0d",
                               $signed(want[31:0]), $signed(m_tdata[31:0]));
                    if (m_tdata[63:32] !== want[63:32])
                        $error("pos_y expected %0d actual %0d",
                               $signed(want[63:32]), $signed(m_tdata[63:32]));
                    if (m_tdata[79:64] !== want[79:64])
                        $error("heading expected %0d actual %0d",
                               $signed(want[79:64]), $signed(m_tdata[79:64]));
                    if (m_tdata[111:80] !== want[111:80])
                        $error("speed expected %0d actual %0d",
                               want[111:80], m_tdata[111:80]);
                    if (m_tdata !== want)
                        fail_count <= fail_count + 1;
                end
            end
            pending <= pose_queue.size();
        end
    end
endmodule
`default_nettype wire

/* verif/differential_drive_odometry_test.sv */
// Testbench top that drives encoder, load and no-change words into the odometry block and gives the verdict.
`default_nettype none
module differential_drive_odometry_test;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [ddo_pkg::IN_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [ddo_pkg::OUT_W-1:0] m_tdata;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int fail_count;
    int pending;
    int results_seen;
    int sent_words = 0;
    int idle_cycles = 0;
    bit calm_phase = 1'b0;
    bit hold_receiver = 1'b0;
    bit timed_out = 1'b0;

    always #5 clk = ~clk;

    differential_drive_odometry u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    odometry_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
    );

    // The receiver stalls in random bursts, or for a long stretch when asked.
    initial
    begin
        int burst;
        int held;
        @(posedge rst_n);
        forever
        begin
            if (hold_receiver)
            begin
                m_tready <= 1'b0;
                for (held = 0; held < 300; held++)
                    @(posedge clk);
                hold_receiver = 1'b0;
            end
            else if (!calm_phase && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 14);
                m_tready <= 1'b0;
                repeat (burst) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000 && !timed_out)
        begin
            timed_out = 1'b1;
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_word(input logic [1:0] mode, input logic [15:0] lc,
                             input logic [15:0] rc, input logic [31:0] lx,
                             input logic [31:0] ly, input logic [15:0] lh);
        int burst;
        if (!calm_phase && $urandom_range(0, 6) == 0)
        begin
            burst = $urandom_range(1, 14);
            s_tvalid <= 1'b0;
            repeat (burst) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {lh, ly, lx, rc, lc};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_words++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0 || m_tvalid)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_count(input int spread);
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(-$urandom_range(0, spread));
            default: return 16'($urandom_range(0, 2 * spread) - spread);
        endcase
    endfunction

    task automatic random_words(input int count, input int spread);
        logic [1:0] mode;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 15))
                0: mode = ddo_pkg::MODE_LOAD_XY;
                1: mode = ddo_pkg::MODE_LOAD_HD;
                2: mode = ddo_pkg::MODE_HOLD;
                default: mode = ddo_pkg::MODE_ENC;
            endcase
            send_word(mode, pick_count(spread), pick_count(spread),
                      $urandom, $urandom, 16'($urandom));
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at reset settings: extremes, all modes, wrap.
        send_word(ddo_pkg::MODE_ENC, 16'd0, 16'd0, '0, '0, '0);
        send_word(ddo_pkg::MODE_ENC, 16'd100, 16'd100, '0, '0, '0);
        send_word(ddo_pkg::MODE_ENC, 16'h7FFF, 16'h7FFF, '0, '0, '0);
        send_word(ddo_pkg::MODE_ENC, 16'h8000, 16'h8000, '0, '0, '0);
        send_word(ddo_pkg::MODE_ENC, 16'h7FFF, 16'h8000, '0, '0, '0);
        send_word(ddo_pkg::MODE_ENC, 16'h8000, 16'h7FFF, '0, '0, '0);
        send_word(ddo_pkg::MODE_LOAD_XY, 16'hFFFF, 16'hFFFF, 32'h7FFFFFFF, 32'h80000000,
                  16'hFFFF);
        send_word(ddo_pkg::MODE_ENC, 16'h0400, 16'h0400, '0, '0, '0);
        send_word(ddo_pkg::MODE_LOAD_HD, '0, '0, '1, '1, 16'h7FFF);
        send_word(ddo_pkg::MODE_ENC, 16'd50, 16'hFFCE, '0, '0, '0);
        send_word(ddo_pkg::MODE_LOAD_HD, '0, '0, '0, '0, 16'h8000);
        send_word(ddo_pkg::MODE_ENC, 16'd300, 16'd200, '0, '0, '0);
        send_word(ddo_pkg::MODE_HOLD, 16'hFFFF, 16'hFFFF, '1, '1, 16'hFFFF);
        send_word(ddo_pkg::MODE_LOAD_XY, '0, '0, 32'h80000000, 32'h7FFFFFFF, '0);
        send_word(ddo_pkg::MODE_ENC, 16'h4000, 16'hC000, '0, '0, '0);
        drain_results();

        // Extreme settings, zero rate included.
        write_reg(ddo_pkg::REG_DIST, 32'hFFFFFF);
        write_reg(ddo_pkg::REG_TURN, 32'hFFFFFFFF);
        write_reg(ddo_pkg::REG_RATE, 32'hFFFF);
        send_word(ddo_pkg::MODE_ENC, 16'h7FFF, 16'h7FFF, '0, '0, '0);
        send_word(ddo_pkg::MODE_ENC, 16'h8000, 16'h7FFF, '0, '0, '0);
        send_word(ddo_pkg::MODE_ENC, 16'h8000, 16'h8000, '0, '0, '0);
        random_words(80, 32768);
        drain_results();
        write_reg(ddo_pkg::REG_DIST, 32'd0);
        write_reg(ddo_pkg::REG_TURN, 32'd0);
        write_reg(ddo_pkg::REG_RATE, 32'd0);
        random_words(40, 32768);
        drain_results();

        // Long receiver hold while words keep coming.
        write_reg(ddo_pkg::REG_DIST, 32'd65536);
        write_reg(ddo_pkg::REG_TURN, 32'd65536);
        write_reg(ddo_pkg::REG_RATE, 32'd1);
        hold_receiver = 1'b1;
        random_words(20, 500);
        drain_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            write_reg(ddo_pkg::REG_DIST, $urandom_range(0, 24'hFFFFFF));
            write_reg(ddo_pkg::REG_TURN, $urandom);
            write_reg(ddo_pkg::REG_RATE, $urandom_range(1, 65535));
            random_words(80, phase[0] ? 2000 : 32768);
            drain_results();
        end
        calm_phase = 1'b1;
        random_words(80, 1000);
        drain_results();

        $display("Covered %0d words and %0d results over all modes and register extremes.",
                 sent_words, results_seen);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
